// File: rtl/mlse_pkg.sv
package mlse_pkg;

  localparam int SLOTS_DEF   = 64;
  localparam int DIV_STEPS   = 32;
  localparam int SQRT_STEPS  = 17;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam logic [15:0] RATE_RESET = 16'd16000;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIFF = 8'b0000_0010,
    ST_SQ   = 8'b0000_0100,
    ST_SUM  = 8'b0000_1000,
    ST_ITER = 8'b0001_0000,
    ST_SAT  = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load_in;
    logic diff;
    logic square;
    logic sum;
    logic div_step;
    logic sqrt_step;
    logic sat;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: rtl/mlse_ctrl.sv
module mlse_ctrl import mlse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load_in = accept;
        if (accept) state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.div_step  = 1'b1;
        cmd.sqrt_step = (32'(cnt_r) < SQRT_STEPS);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        cmd.fin = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/mlse_datapath.sv
module mlse_datapath import mlse_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [5:0]         in_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_heading,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_slot_out,
  output logic signed [31:0] out_slope,
  output logic signed [31:0] out_intercept,
  output logic [31:0]        out_speed,
  output logic signed [31:0] out_angular_velocity
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [47:0]        mem [SLOTS];
  logic [SLOTS-1:0]   vld_r;
  logic [47:0]        rd_r;
  logic               hit_r;
  logic [15:0]        rate_r;

  logic [5:0]         slot_r;
  logic signed [15:0] x_r, y_r, th_r;
  logic [IW-1:0]      idx_r;
  logic               ok_r;
  logic               in_ok;
  logic [IW-1:0]      in_idx;

  logic signed [16:0] dx_r, dy_r, dth_r;
  logic               line_r;
  logic [32:0]        sqx_r, sqy_r;
  logic signed [33:0] angp_r;

  logic [15:0]        den_r;
  logic [15:0]        rem_r;
  logic [31:0]        quo_r;
  logic               neg_r;
  logic [16:0]        div_t;
  logic               div_ge;

  logic [33:0]        sq_r;
  logic [19:0]        srem_r;
  logic [16:0]        root_r;
  logic [19:0]        sq_sh, sq_trial;
  logic               sq_ge;

  logic signed [31:0] slope_r;
  logic signed [47:0] prod_r;
  logic [32:0]        spd_r;

  logic signed [15:0] px, py, pth;
  logic signed [33:0] icpt_w;
  logic signed [31:0] icpt_sat;
  logic               out_valid_r;

  assign in_ok  = (32'(in_slot) < SLOTS);
  assign in_idx = IW'(in_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) rate_r <= RATE_RESET;
    else if (cfg_valid && cfg_ready) rate_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) rd_r <= mem[in_idx];
    if (cmd.diff && ok_r) mem[idx_r] <= {x_r, y_r, th_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.load_in) hit_r <= in_ok && vld_r[in_idx];
      if (cmd.diff && ok_r) vld_r[idx_r] <= 1'b1;
    end
  end

  assign px  = hit_r ? $signed(rd_r[47:32]) : 16'sd0;
  assign py  = hit_r ? $signed(rd_r[31:16]) : 16'sd0;
  assign pth = hit_r ? $signed(rd_r[15:0])  : 16'sd0;

  assign div_t  = {rem_r, quo_r[31]};
  assign div_ge = (div_t >= {1'b0, den_r});

  assign sq_sh    = {srem_r[17:0], sq_r[33:32]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  assign icpt_w = $signed({{18{y_r[15]}}, y_r}) - $signed({{2{prod_r[47]}}, prod_r[47:16]});

  always_comb begin
    if (icpt_w[33:31] == 3'b000 || icpt_w[33:31] == 3'b111) icpt_sat = icpt_w[31:0];
    else if (icpt_w[33]) icpt_sat = 32'sh8000_0000;
    else icpt_sat = 32'sh7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      slot_r <= in_slot;
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      th_r   <= in_heading;
      idx_r  <= in_idx;
      ok_r   <= in_ok;
    end
    if (cmd.diff) begin
      dx_r  <= 17'(px) - 17'(x_r);
      dy_r  <= 17'(py) - 17'(y_r);
      dth_r <= 17'(pth) - 17'(th_r);
    end
    if (cmd.square) begin
      sqx_r  <= 33'(dx_r * dx_r);
      sqy_r  <= 33'(dy_r * dy_r);
      angp_r <= dth_r * $signed({1'b0, rate_r});
      line_r <= (dx_r != 17'sd0) && (dy_r != 17'sd0);
      neg_r  <= dx_r[16] ^ dy_r[16];
      den_r  <= dx_r[16] ? 16'(-dx_r) : dx_r[15:0];
      quo_r  <= {(dy_r[16] ? 16'(-dy_r) : dy_r[15:0]), 16'd0};
      rem_r  <= '0;
    end
    if (cmd.sum) begin
      sq_r   <= {1'b0, sqx_r + sqy_r};
      srem_r <= '0;
      root_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? 16'(div_t - {1'b0, den_r}) : div_t[15:0];
      quo_r <= {quo_r[30:0], div_ge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
      root_r <= {root_r[15:0], sq_ge};
      sq_r   <= {sq_r[31:0], 2'b00};
    end
    if (cmd.sat) begin
      if (neg_r) slope_r <= (quo_r > 32'h8000_0000) ? 32'sh8000_0000 : $signed(~quo_r + 1'b1);
      else       slope_r <= quo_r[31] ? 32'sh7FFF_FFFF : $signed(quo_r);
    end
    if (cmd.mul) begin
      prod_r <= slope_r * x_r;
      spd_r  <= root_r * rate_r;
    end
    if (cmd.fin) begin
      out_slot_out         <= slot_r;
      out_slope            <= line_r ? slope_r : 32'sd0;
      out_intercept        <= line_r ? icpt_sat : 32'(y_r);
      out_speed            <= line_r ? {7'd0, spd_r[32:8]} : 32'd0;
      out_angular_velocity <= {{6{angp_r[33]}}, angp_r[33:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.fin) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// File: rtl/motion_line_speed_estimator.sv
// Channel | Direction | Ports                                         | Transfer when
// in      | input     | in_valid, in_stall, in_slot/pos_x/pos_y/head.. | valid && !stall
// out     | output    | out_valid, out_stall, out_slot_out..out_angular | valid && !stall
// cfg     | input     | cfg_valid, cfg_ready, cfg_data                | valid && ready
//
// An item runs from its input transfer through the difference, square and sum
// steps, the 32-step restoring divider for the slope with the 17-step square
// root running alongside it, and the saturation, multiply and final steps. The
// next item is taken once the result is loaded, while that result still waits
// in the output register, so no new item is taken before the last is loaded.
// Reset (synchronous, active low) marks every slot's stored pose as zero through
// per-slot valid bits and sets the rate register to 16000. A stalled output
// holds its result; the sequencer holds in its last step until the output frees.
module motion_line_speed_estimator import mlse_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         in_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_slot_out,
  output logic signed [31:0] out_slope,
  output logic signed [31:0] out_intercept,
  output logic [31:0]        out_speed,
  output logic signed [31:0] out_angular_velocity,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // accept rate writes at any time; the user must let them arrive only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  mlse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlse_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_slot              (in_slot),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_heading           (in_heading),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_slot_out         (out_slot_out),
    .out_slope            (out_slope),
    .out_intercept        (out_intercept),
    .out_speed            (out_speed),
    .out_angular_velocity (out_angular_velocity)
  );

endmodule
